@@ rtl/edit_distance_engine_defines.svh @@
// assertion macros for the edit distance engine checker
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// consequent checked at the same edge, quiet while reset is held
`define EDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked one edge later, quiet while reset is held
`define EDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked one edge later, live during reset as well
`define EDE_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ede_pkg.sv @@
// shared constants and types for the edit distance engine
`default_nettype none

package ede_pkg;

    // word capacity and derived widths
    localparam int MAX_LEN  = 256;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CHAR_W   = 16;
    localparam int ACT_W    = 2;
    localparam int DIST_W   = 9;
    localparam int DIST_MAX = 511;

    // action codes of an input word
    typedef enum logic [ACT_W-1:0] {
        ACT_FIRST   = 2'd0,
        ACT_SECOND  = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_FINISH
    } t_state;

    typedef logic [LEN_W-1:0] t_len;

endpackage

`default_nettype wire

@@ rtl/ede_channels.sv @@
// handshake channels of the edit distance engine
`default_nettype none

interface ede_item_if;
    import ede_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface ede_res_if;
    import ede_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/ede_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module ede_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/edit_distance_engine.sv @@
// edit distance engine: word stores, row memories and the cell sequencer
//
//   channel   direction  payload               handshake
//   i_item    in         action, char_code     valid / ready
//   o_res     out        distance, overflow    valid / ready
//   cfg       in         allow_transpose bit   i_cfg_we, no wait
//
// a character word is taken every cycle while idle. a compute word works
// one matrix cell per cycle, with a row set-up state before each row; the
// pace is set by the three row memories (one read and one write per cycle).
// with an empty word the compute goes straight to the finish state.
// ready is low from a compute until its result sits in the output register;
// a waiting result does not block character words. reset is synchronous.
`default_nettype none

module edit_distance_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    ede_item_if.sink  i_item,
    ede_res_if.source o_res
);
    import ede_pkg::*;

    // control state
    t_state r_state, n_state;
    logic   r_xpose, n_xpose;
    t_len   r_n1, n_n1;
    t_len   r_n2, n_n2;
    logic   r_dropped, n_dropped;
    logic [1:0] r_role, n_role;
    logic   r_out_valid, n_out_valid;

    // datapath registers
    t_len r_i, n_i;
    t_len r_j, n_j;
    t_len r_cur_lag, n_cur_lag;
    t_len r_prev_lag, n_prev_lag;
    t_len r_dist, n_dist;
    logic [CHAR_W-1:0] r_s_prev, n_s_prev;
    logic [CHAR_W-1:0] r_f_lag, n_f_lag;
    logic [DIST_W-1:0] r_out_dist, n_out_dist;
    logic r_out_ovf, n_out_ovf;

    // memory hookup
    logic              in_ready;
    logic              fw_we, sw_we, sw_rd_en, row_we;
    logic [ADDR_W-1:0] fw_rd_addr, sw_rd_addr;
    logic [CHAR_W-1:0] fw_q, sw_q;
    t_len              i_minus1;
    t_len              prev_addr, tb_addr;
    t_len              row_q [3];
    logic [1:0]        prev_idx, tb_idx;
    t_len              prev_q, tb_q;

    // cell arithmetic
    t_len       prev_v, tb_v, cell_val;
    logic       sub, trans_ok;
    logic [LEN_W:0] c_del, c_ins, c_sub, c_tr, c_best;

    function automatic logic [DIST_W-1:0] f_sat(input t_len v);
        logic [DIST_W-1:0] res;
        if (32'(v) > 32'(DIST_MAX)) begin
            res = DIST_W'(DIST_MAX);
        end else begin
            res = DIST_W'(v);
        end
        return res;
    endfunction

    // word stores
    ede_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first (
        .i_clk     (i_clk),
        .i_wr_en   (fw_we),
        .i_wr_addr (r_n1[ADDR_W-1:0]),
        .i_wr_data (i_item.char_code),
        .i_rd_en   (1'b1),
        .i_rd_addr (fw_rd_addr),
        .o_rd_data (fw_q)
    );

    ede_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second (
        .i_clk     (i_clk),
        .i_wr_en   (sw_we),
        .i_wr_addr (r_n2[ADDR_W-1:0]),
        .i_wr_data (i_item.char_code),
        .i_rd_en   (sw_rd_en),
        .i_rd_addr (sw_rd_addr),
        .o_rd_data (sw_q)
    );

    // row roles rotate: current, previous, two back
    always_comb begin
        unique case (r_role)
            2'd0: begin
                prev_idx = 2'd1;
                tb_idx   = 2'd2;
            end
            2'd1: begin
                prev_idx = 2'd2;
                tb_idx   = 2'd0;
            end
            2'd2: begin
                prev_idx = 2'd0;
                tb_idx   = 2'd1;
            end
            default: begin
                prev_idx = 2'd1;
                tb_idx   = 2'd2;
            end
        endcase
    end

    // three row memories
    for (genvar k = 0; k < 3; k++) begin : g_row
        ede_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_row (
            .i_clk     (i_clk),
            .i_wr_en   (row_we && (r_role == 2'(k))),
            .i_wr_addr (r_j),
            .i_wr_data (cell_val),
            .i_rd_en   (1'b1),
            .i_rd_addr ((prev_idx == 2'(k)) ? prev_addr : tb_addr),
            .o_rd_data (row_q[k])
        );
    end

    assign prev_q = row_q[prev_idx];
    assign tb_q   = row_q[tb_idx];

    // read addresses for the next cell
    always_comb begin
        i_minus1   = r_i - t_len'(1);
        sw_rd_addr = i_minus1[ADDR_W-1:0];
        tb_addr    = r_j - t_len'(1);
        if (r_state == ST_ROW) begin
            prev_addr  = t_len'(1);
            fw_rd_addr = '0;
        end else begin
            prev_addr  = r_j + t_len'(1);
            fw_rd_addr = r_j[ADDR_W-1:0];
        end
    end

    // one matrix cell; row zero and column zero are implied
    always_comb begin
        prev_v = (r_i == t_len'(1)) ? r_j : prev_q;
        if (r_i == t_len'(2)) begin
            tb_v = r_j - t_len'(2);
        end else if (r_j == t_len'(2)) begin
            tb_v = r_i - t_len'(2);
        end else begin
            tb_v = tb_q;
        end
        sub      = (fw_q != sw_q);
        trans_ok = r_xpose && (r_i > t_len'(1)) && (r_j > t_len'(1))
                   && (fw_q == r_s_prev) && (r_f_lag == sw_q);
        c_del = {1'b0, prev_v} + (LEN_W + 1)'(1);
        c_ins = {1'b0, r_cur_lag} + (LEN_W + 1)'(1);
        c_sub = {1'b0, r_prev_lag} + (LEN_W + 1)'(sub);
        c_tr  = {1'b0, tb_v} + (LEN_W + 1)'(1);
        c_best = (c_del < c_ins) ? c_del : c_ins;
        if (c_sub < c_best) begin
            c_best = c_sub;
        end
        if (trans_ok && (c_tr < c_best)) begin
            c_best = c_tr;
        end
        cell_val = c_best[LEN_W-1:0];
    end

    // sequencer: next state and controls
    always_comb begin
        n_state     = r_state;
        n_xpose     = r_xpose;
        n_n1        = r_n1;
        n_n2        = r_n2;
        n_dropped   = r_dropped;
        n_role      = r_role;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_j         = r_j;
        n_cur_lag   = r_cur_lag;
        n_prev_lag  = r_prev_lag;
        n_dist      = r_dist;
        n_s_prev    = r_s_prev;
        n_f_lag     = r_f_lag;
        n_out_dist  = r_out_dist;
        n_out_ovf   = r_out_ovf;
        in_ready    = 1'b0;
        fw_we       = 1'b0;
        sw_we       = 1'b0;
        sw_rd_en    = 1'b0;
        row_we      = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_xpose = i_cfg_wdata;
        end

        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_item.valid) begin
                    case (i_item.action)
                        ACT_FIRST: begin
                            if (r_n1 < t_len'(MAX_LEN)) begin
                                fw_we = 1'b1;
                                n_n1  = r_n1 + t_len'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        ACT_SECOND: begin
                            if (r_n2 < t_len'(MAX_LEN)) begin
                                sw_we = 1'b1;
                                n_n2  = r_n2 + t_len'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        ACT_COMPUTE: begin
                            if (r_n1 == '0 || r_n2 == '0) begin
                                n_dist  = (r_n1 == '0) ? r_n2 : r_n1;
                                n_state = ST_FINISH;
                            end else begin
                                n_i     = t_len'(1);
                                n_state = ST_ROW;
                            end
                        end
                        default: begin
                            // unused code, word dropped silently
                        end
                    endcase
                end
            end
            ST_ROW: begin
                sw_rd_en   = 1'b1;
                n_s_prev   = sw_q;
                n_cur_lag  = r_i;
                n_prev_lag = i_minus1;
                n_j        = t_len'(1);
                n_state    = ST_CELL;
            end
            ST_CELL: begin
                row_we     = 1'b1;
                n_cur_lag  = cell_val;
                n_prev_lag = prev_v;
                n_f_lag    = fw_q;
                if (r_j == r_n1) begin
                    if (r_i == r_n2) begin
                        n_dist  = cell_val;
                        n_state = ST_FINISH;
                    end else begin
                        n_role  = (r_role == 2'd0) ? 2'd2 : r_role - 2'd1;
                        n_i     = r_i + t_len'(1);
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j = r_j + t_len'(1);
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = f_sat(r_dist);
                    n_out_ovf   = r_dropped;
                    n_n1        = '0;
                    n_n2        = '0;
                    n_dropped   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_xpose     <= 1'b1;
            r_n1        <= '0;
            r_n2        <= '0;
            r_dropped   <= 1'b0;
            r_role      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_xpose     <= n_xpose;
            r_n1        <= n_n1;
            r_n2        <= n_n2;
            r_dropped   <= n_dropped;
            r_role      <= n_role;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_cur_lag  <= n_cur_lag;
        r_prev_lag <= n_prev_lag;
        r_dist     <= n_dist;
        r_s_prev   <= n_s_prev;
        r_f_lag    <= n_f_lag;
        r_out_dist <= n_out_dist;
        r_out_ovf  <= n_out_ovf;
    end

    // ports
    assign i_item.ready   = in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.distance = r_out_dist;
    assign o_res.overflow = r_out_ovf;

endmodule

`default_nettype wire

@@ rtl/ede_chk.sv @@
// port-level checker for the edit distance engine, with its bind
`default_nettype none
`include "edit_distance_engine_defines.svh"

module ede_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic [ede_pkg::ACT_W-1:0]  i_in_action,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [ede_pkg::DIST_W-1:0] i_out_distance,
    input wire logic                       i_out_overflow
);
    import ede_pkg::*;

    // reset empties the output register
    `EDE_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // a stalled result word holds
    `EDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_distance) && $stable(i_out_overflow), "stalled result changed")

    // a compute word closes the input until its result is placed
    `EDE_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_action == ACT_COMPUTE), !i_in_ready, "input open right after a compute")

    // a new result only comes out of a compute, while input is closed
    `EDE_ASSERT_SAME(a_res_src, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result without a compute")

    // the distance never exceeds the word capacity
    `EDE_ASSERT_SAME(a_dist_range, i_clk, i_rst_n, i_out_valid, 32'(i_out_distance) <= 32'(MAX_LEN), "distance beyond word capacity")

endmodule

bind edit_distance_engine ede_chk u_ede_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_action    (i_item.action),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_distance (o_res.distance),
    .i_out_overflow (o_res.overflow)
);

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the edit distance engine: directed table, then random strings
`timescale 1ns / 1ps

module tb_top;
    import ede_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 11;
    localparam int SETTLE_GAP   = 8;
    localparam int RANDOM_WORDS = 1400;
    localparam int PHASE_WORDS  = 350;
    localparam int LIMIT_CYCLES = 600000;

    // action code the block leaves alone
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_outcome;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    // one row of the opening table; for a register row bit 0 of code is the value
    typedef struct packed {
        t_row_kind         kind;
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] code;
        logic              typed;
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_row;

    localparam int OPENING_ROWS = 28;

    t_row opening [OPENING_ROWS] = '{
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b1, 9'd0, 1'b0},
        '{ROW_WORD, ACT_UNUSED,  16'hFFFF, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b1, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0000, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'hFFFF, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h8001, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'hFFFF, 1'b1, 9'd3, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'hFFFF, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0000, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b1, 9'd2, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0062, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0062, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b1, 9'd1, 1'b0},
        '{ROW_CFG,  ACT_FIRST,   16'h0000, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0062, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0062, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b1, 9'd2, 1'b0},
        '{ROW_CFG,  ACT_FIRST,   16'h0001, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0063, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_FIRST,   16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0061, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0062, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_SECOND,  16'h0063, 1'b0, 9'd0, 1'b0},
        '{ROW_WORD, ACT_COMPUTE, 16'h0000, 1'b0, 9'd0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ede_item_if item_ch ();
    ede_res_if  res_ch ();

    // shadow of the block state
    logic [CHAR_W-1:0] first_chars [$];
    logic [CHAR_W-1:0] second_chars [$];
    bit                dropped_char;
    bit                transpose_on;

    // results still owed by the block
    t_outcome awaited_results [$];

    // strings being built by the random part
    logic [CHAR_W-1:0] draft_first [$];
    logic [CHAR_W-1:0] draft_second [$];

    int mismatches;
    int words_sent;
    bit steady;

    edit_distance_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_res       (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // optimal string alignment distance over the shadow strings, three rows kept
    function automatic int unsigned align_distance();
        int unsigned two_back [MAX_LEN + 1];
        int unsigned prev_row [MAX_LEN + 1];
        int unsigned cur_row  [MAX_LEN + 1];
        int unsigned best;
        int unsigned sub;
        int          n1;
        int          n2;
        int          i;
        int          j;
        n1 = first_chars.size();
        n2 = second_chars.size();
        for (j = 0; j <= n1; j++)
            prev_row[j] = j;
        for (i = 1; i <= n2; i++) begin
            cur_row[0] = i;
            for (j = 1; j <= n1; j++) begin
                sub  = (first_chars[j-1] == second_chars[i-1]) ? 0 : 1;
                best = (prev_row[j] < cur_row[j-1]) ? prev_row[j] + 1 : cur_row[j-1] + 1;
                if (prev_row[j-1] + sub < best)
                    best = prev_row[j-1] + sub;
                if (transpose_on && i > 1 && j > 1 &&
                    first_chars[j-1] == second_chars[i-2] &&
                    first_chars[j-2] == second_chars[i-1] &&
                    two_back[j-2] + 1 < best)
                    best = two_back[j-2] + 1;
                cur_row[j] = best;
            end
            two_back = prev_row;
            prev_row = cur_row;
        end
        return (prev_row[n1] > DIST_MAX) ? DIST_MAX : prev_row[n1];
    endfunction

    function automatic logic [CHAR_W-1:0] random_char(input bit wide);
        return wide ? CHAR_W'($urandom) : CHAR_W'(16'h0061 + $urandom_range(3));
    endfunction

    // drive one word, wait for it to be taken, then update the shadow state
    task automatic push_word(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] code,
                             input logic typed, input logic [DIST_W-1:0] typed_dist,
                             input logic typed_ovf);
        t_outcome got;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= act;
        item_ch.char_code <= code;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        if (act != ACT_UNUSED)
            words_sent++;
        case (act)
            ACT_FIRST: begin
                if (first_chars.size() < MAX_LEN)
                    first_chars.insert(first_chars.size(), code);
                else
                    dropped_char = 1'b1;
            end
            ACT_SECOND: begin
                if (second_chars.size() < MAX_LEN)
                    second_chars.insert(second_chars.size(), code);
                else
                    dropped_char = 1'b1;
            end
            ACT_COMPUTE: begin
                got.distance = DIST_W'(align_distance());
                got.overflow = dropped_char;
                if (typed) begin
                    got.distance = typed_dist;
                    got.overflow = typed_ovf;
                end
                awaited_results.insert(awaited_results.size(), got);
                first_chars.delete();
                second_chars.delete();
                dropped_char = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // register write once the block has gone quiet
    task automatic write_transpose(input bit value);
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        transpose_on = value;
    endtask

    // one pair of random strings, half of them near copies, with some noise words
    task automatic random_pair();
        int style;
        int n;
        int k;
        int m;
        int ia;
        int ib;
        bit wide;
        logic [CHAR_W-1:0] tmp;
        draft_first.delete();
        draft_second.delete();
        style = $urandom_range(9);
        wide  = (style >= 8) || ($urandom_range(4) == 0);
        n = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(10);
        for (k = 0; k < n; k++)
            draft_first.insert(draft_first.size(), random_char(wide));
        if (style < 5) begin
            // near copy: one to three edits, each a swap, substitution, insertion or deletion
            draft_second = draft_first;
            for (m = $urandom_range(1, 3); m > 0; m--) begin
                k = $urandom_range(3);
                if (k == 0 && draft_second.size() >= 2) begin
                    ia = $urandom_range(draft_second.size() - 2);
                    tmp = draft_second[ia];
                    draft_second[ia] = draft_second[ia+1];
                    draft_second[ia+1] = tmp;
                end else if (k == 1 && draft_second.size() >= 1) begin
                    draft_second[$urandom_range(draft_second.size() - 1)] = random_char(wide);
                end else if (k == 2) begin
                    draft_second.insert($urandom_range(draft_second.size()), random_char(wide));
                end else if (draft_second.size() >= 1) begin
                    draft_second.delete($urandom_range(draft_second.size() - 1));
                end
            end
        end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(10);
            for (k = 0; k < n; k++)
                draft_second.insert(draft_second.size(), random_char(wide));
        end
        ia = 0;
        ib = 0;
        while (ia < draft_first.size() || ib < draft_second.size()) begin
            if ($urandom_range(19) == 0)
                push_word(ACT_UNUSED, CHAR_W'($urandom), 1'b0, '0, 1'b0);
            if (ib >= draft_second.size() || (ia < draft_first.size() && $urandom_range(1))) begin
                push_word(ACT_FIRST, draft_first[ia], 1'b0, '0, 1'b0);
                ia++;
            end else begin
                push_word(ACT_SECOND, draft_second[ib], 1'b0, '0, 1'b0);
                ib++;
            end
        end
        // now and then the strings run on into the next pair
        if ($urandom_range(24) != 0)
            push_word(ACT_COMPUTE, CHAR_W'($urandom), 1'b0, '0, 1'b0);
    endtask

    // result sink: random back-pressure, quiet during the steady stretch
    always @(posedge i_clk)
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with none pending: distance %0d overflow %0b",
                                        res_ch.distance, res_ch.overflow));
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.distance !== want.distance)
                    flag_mismatch($sformatf("distance %0d, expected %0d",
                                            res_ch.distance, want.distance));
                if (res_ch.overflow !== want.overflow)
                    flag_mismatch($sformatf("overflow %0b, expected %0b",
                                            res_ch.overflow, want.overflow));
            end
        end
    end

    // stimulus
    initial begin
        int r;
        int k;
        int phase;
        bit long_done;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.action    = ACT_FIRST;
        item_ch.char_code = '0;
        res_ch.ready      = 1'b0;
        transpose_on      = 1'b1;
        dropped_char      = 1'b0;
        mismatches        = 0;
        words_sent        = 0;
        steady            = 1'b0;
        phase             = 0;
        long_done         = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening table
        for (r = 0; r < OPENING_ROWS; r++) begin
            if (opening[r].kind == ROW_CFG)
                write_transpose(opening[r].code[0]);
            else
                push_word(opening[r].action, opening[r].code, opening[r].typed,
                          opening[r].distance, opening[r].overflow);
        end

        // random part in register phases
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent / PHASE_WORDS != phase) begin
                phase = words_sent / PHASE_WORDS;
                write_transpose((phase == 3) ? 1'($urandom_range(1)) : !phase[0]);
            end
            steady = (words_sent >= 400 && words_sent < 600);
            if (!long_done && words_sent >= 800) begin
                // both strings filled past capacity, no common characters
                long_done = 1'b1;
                for (k = 0; k < MAX_LEN + 2; k++)
                    push_word(ACT_FIRST, CHAR_W'(16'h1000 + k), 1'b0, '0, 1'b0);
                for (k = 0; k < MAX_LEN + 1; k++)
                    push_word(ACT_SECOND, CHAR_W'(16'h2000 + k), 1'b0, '0, 1'b0);
                push_word(ACT_COMPUTE, 16'h0000, 1'b0, '0, 1'b0);
            end else begin
                random_pair();
            end
        end
        push_word(ACT_COMPUTE, 16'h0000, 1'b0, '0, 1'b0);
        item_ch.valid <= 1'b0;

        // drain
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("edit_distance_engine verification clean");
        else
            $display("edit_distance_engine verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("edit_distance_engine verification failed");
        $finish;
    end

endmodule
